[hdl/mexp_pkg.sv]
// Shared types and constants of the modular exponentiation unit.
// No dependencies; the files that use it refer to it by scoped names.
package mexp_pkg;

    localparam int BASE_W  = 64;  // width of the base field
    localparam int PADDR_W = 4;   // register file address width
    localparam int PDATA_W = 64;  // register file data width

    // tag that travels with an operation through the cell chain
    typedef enum logic [1:0] {
        TAG_RED,   // base reduction pass
        TAG_SQ,    // square of the running power
        TAG_MUL    // product of result and power
    } t_tag;

    typedef struct packed {
        logic vld;
        t_tag tag;
    } t_ctl;

endpackage

[hdl/mexp_if.sv]
// Valid/ready channel interfaces of the modular exponentiation unit.
// No dependencies.
interface mexp_in_if #(
    parameter int EXP_W = 16
);
    logic             valid;
    logic             ready;
    logic [63:0]      base_value;
    logic [EXP_W-1:0] exponent;

    modport source (output valid, base_value, exponent, input ready);
    modport sink   (input valid, base_value, exponent, output ready);
endinterface

interface mexp_out_if #(
    parameter int MOD_W = 48
);
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] power_result;

    modport source (output valid, power_result, input ready);
    modport sink   (input valid, power_result, output ready);
endinterface

[hdl/modular_exponentiation_unit.sv]
// Modular exponentiation, right-to-left square-and-multiply, top level.
// The base is first reduced in NPASS chain passes (NPASS = ceil(64/MOD_WIDTH)), then each
// exponent bit up to the highest set one takes a square pass and, when the bit is set, a
// product pass; S_EXP then finds no set bits left and S_DONE registers the result.
// One item at a time: the next beat is taken once the result is registered for output.
// Reset is synchronous, active low: control clears, modulus returns to all ones.
// Depends on mexp_pkg, mexp_if, mexp_chain and mexp_cell.
module modular_exponentiation_unit #(
    parameter int EXP_WIDTH = 16,
    parameter int MOD_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mexp_in_if.sink                       i_in_ch,
    mexp_out_if.source                    o_out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mexp_pkg::PADDR_W-1:0]  paddr,
    input  logic [mexp_pkg::PDATA_W-1:0]  pwdata,
    output logic [mexp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    // number of chain passes that fold the 64-bit base into the modulus
    localparam int NPASS = (mexp_pkg::BASE_W + MOD_WIDTH - 1) / MOD_WIDTH;
    localparam int PADW  = NPASS * MOD_WIDTH;
    localparam int PCW   = $clog2(NPASS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RED, S_RWAIT, S_EXP, S_MUL, S_WAIT, S_DONE
    } t_state;

    t_state                r_state;
    logic [MOD_WIDTH-1:0]  r_modulus;
    logic [PADW-1:0]       r_bsh;
    logic [PCW-1:0]        r_pass;
    logic [MOD_WIDTH-1:0]  r_power;
    logic [MOD_WIDTH-1:0]  r_result;
    logic [EXP_WIDTH-1:0]  r_exp;
    logic                  r_zero;
    logic                  r_mul_pend;
    logic                  r_out_vld;
    logic [MOD_WIDTH-1:0]  r_out_data;

    logic [MOD_WIDTH-1:0]  w_mod;
    mexp_pkg::t_ctl        w_iss_ctl;
    logic [MOD_WIDTH-1:0]  w_iss_acc;
    logic [MOD_WIDTH-1:0]  w_iss_a;
    logic [MOD_WIDTH-1:0]  w_iss_b;
    mexp_pkg::t_ctl        w_ret_ctl;
    logic [MOD_WIDTH-1:0]  w_ret_acc;
    logic                  w_in_beat;

    // ---------------- register port ----------------
    // Modulus is the only register; a zero modulus acts as one.
    assign pready = 1'b1;
    assign prdata = mexp_pkg::PDATA_W'(r_modulus);
    assign w_mod  = (r_modulus == '0) ? MOD_WIDTH'(1) : r_modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= '1;
        end else if (psel && penable && pwrite && !paddr[3]) begin
            r_modulus <= pwdata[MOD_WIDTH-1:0];
        end
    end

    // ---------------- issue into the chain ----------------
    // Reduction passes shift base bits in MSB first with a multiplicand of one;
    // each exponent bit issues the square and, when the bit is set, the product.
    always_comb begin
        w_iss_ctl = '{vld: 1'b0, tag: mexp_pkg::TAG_RED};
        w_iss_acc = '0;
        w_iss_a   = r_power;
        w_iss_b   = r_power;
        unique case (r_state)
            S_RED: begin
                w_iss_ctl = '{vld: 1'b1, tag: mexp_pkg::TAG_RED};
                w_iss_acc = r_power;
                w_iss_a   = MOD_WIDTH'(1);
                w_iss_b   = r_bsh[PADW-1 -: MOD_WIDTH];
            end
            S_EXP: begin
                w_iss_ctl = '{vld: (r_exp != '0), tag: mexp_pkg::TAG_SQ};
            end
            S_MUL: begin
                w_iss_ctl = '{vld: r_exp[0], tag: mexp_pkg::TAG_MUL};
                w_iss_a   = r_result;
            end
            default: begin
                w_iss_ctl = '{vld: 1'b0, tag: mexp_pkg::TAG_RED};
            end
        endcase
    end

    mexp_chain #(.W(MOD_WIDTH)) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_iss_ctl),
        .i_acc  (w_iss_acc),
        .i_a    (w_iss_a),
        .i_b    (w_iss_b),
        .i_mod  (w_mod),
        .o_ctl  (w_ret_ctl),
        .o_acc  (w_ret_acc)
    );

    // ---------------- sequencer ----------------
    assign i_in_ch.ready = (r_state == S_IDLE);
    assign w_in_beat     = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            // drop the output beat once taken
            if (r_out_vld && o_out_ch.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_bsh    <= PADW'(i_in_ch.base_value);
                        r_pass   <= '0;
                        r_power  <= '0;
                        r_result <= (w_mod == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                        r_exp    <= i_in_ch.exponent;
                        r_zero   <= (i_in_ch.exponent == '0);
                        r_state  <= S_RED;
                    end
                end
                S_RED: begin
                    r_bsh   <= r_bsh << MOD_WIDTH;
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (w_ret_ctl.vld) begin
                        r_power <= w_ret_acc;
                        if (r_pass == PCW'(NPASS - 1)) begin
                            r_state <= S_EXP;
                        end else begin
                            r_pass  <= r_pass + PCW'(1);
                            r_state <= S_RED;
                        end
                    end
                end
                S_EXP: begin
                    // stop once no set exponent bits remain
                    r_state <= (r_exp == '0) ? S_DONE : S_MUL;
                end
                S_MUL: begin
                    r_mul_pend <= r_exp[0];
                    r_exp      <= r_exp >> 1;
                    r_state    <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_ret_ctl.vld) begin
                        if (w_ret_ctl.tag == mexp_pkg::TAG_MUL) begin
                            r_result <= w_ret_acc;
                            r_state  <= S_EXP;
                        end else begin
                            r_power <= w_ret_acc;
                            if (!r_mul_pend) begin
                                r_state <= S_EXP;
                            end
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_vld || o_out_ch.ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= r_zero ? MOD_WIDTH'(1) : r_result;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_ch.valid        = r_out_vld;
    assign o_out_ch.power_result = r_out_data;

    // ---------------- checks ----------------
    a_ret_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ret_ctl.vld |-> (r_state == S_RWAIT || r_state == S_WAIT))
        else $error("chain returned an operation nobody waits for");

    a_operands_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP) |-> (r_power < w_mod && r_result < w_mod))
        else $error("operand not reduced below modulus");

    a_beat_starts_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state == S_RED))
        else $error("accepted beat did not start reduction");

    a_done_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_vld && !o_out_ch.ready) |=> (r_state == S_DONE))
        else $error("result overwrote a pending output beat");
endmodule

[hdl/mexp_cell.sv]
// One step of the interleaved modular multiplier: acc = 2*acc + bit*a mod m.
// Depends on mexp_pkg.
module mexp_cell #(
    parameter int W = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mexp_pkg::t_ctl       i_ctl,
    input  logic [W-1:0]         i_acc,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    input  logic [W-1:0]         i_mod,
    output mexp_pkg::t_ctl       o_ctl,
    output logic [W-1:0]         o_acc,
    output logic [W-1:0]         o_a,
    output logic [W-1:0]         o_b
);
    logic [W+1:0] w_sum;
    logic [W+1:0] w_m1;
    logic [W+1:0] w_m2;
    logic [W+1:0] w_red;

    mexp_pkg::t_ctl r_ctl;
    logic [W-1:0]   r_acc;
    logic [W-1:0]   r_a;
    logic [W-1:0]   r_b;

    always_comb begin
        w_m1  = (W+2)'(i_mod);
        w_m2  = (W+2)'(i_mod) << 1;
        w_sum = ((W+2)'(i_acc) << 1) + (i_b[W-1] ? (W+2)'(i_a) : '0);
        // sum stays below 3m, so at most two subtractions of m
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_acc <= w_red[W-1:0];
        r_a   <= i_a;
        r_b   <= i_b << 1;
    end

    assign o_ctl = r_ctl;
    assign o_acc = r_acc;
    assign o_a   = r_a;
    assign o_b   = r_b;
endmodule

[hdl/mexp_chain.sv]
// Row of W registered multiplier cells; an operation enters each cycle it is issued
// and passes through every cell in turn. Depends on mexp_pkg and mexp_cell.
module mexp_chain #(
    parameter int W = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mexp_pkg::t_ctl i_ctl,
    input  logic [W-1:0]   i_acc,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    input  logic [W-1:0]   i_mod,
    output mexp_pkg::t_ctl o_ctl,
    output logic [W-1:0]   o_acc
);
    mexp_pkg::t_ctl       w_ctl [W+1];
    logic [W:0][W-1:0]    w_acc;
    logic [W:0][W-1:0]    w_a;
    logic [W:0][W-1:0]    w_b;

    assign w_ctl[0] = i_ctl;
    assign w_acc[0] = i_acc;
    assign w_a[0]   = i_a;
    assign w_b[0]   = i_b;

    for (genvar k = 0; k < W; k++) begin : g_cell
        mexp_cell #(.W(W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl[k]),
            .i_acc  (w_acc[k]),
            .i_a    (w_a[k]),
            .i_b    (w_b[k]),
            .i_mod  (i_mod),
            .o_ctl  (w_ctl[k+1]),
            .o_acc  (w_acc[k+1]),
            .o_a    (w_a[k+1]),
            .o_b    (w_b[k+1])
        );
    end

    assign o_ctl = w_ctl[W];
    assign o_acc = w_acc[W];
endmodule
